// ===== rtl/core/y2r_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_pkg
// shared constants, format codes and pixel helpers for the yuv to rgb555 path
// ----------------------------------------------------------------------------
package y2r_pkg;

  localparam int unsigned FMT_W = 2;
  localparam int unsigned PIX_W = 15;

  // source format codes
  localparam logic [FMT_W-1:0] FMT_YUY2 = 2'd0;
  localparam logic [FMT_W-1:0] FMT_UYVY = 2'd1;
  localparam logic [FMT_W-1:0] FMT_YV12 = 2'd2;

  // 16.16 studio-range matrix
  localparam logic signed [27:0] K_Y  = 28'sd76284;
  localparam logic signed [27:0] K_UB = 28'sd132252;
  localparam logic signed [27:0] K_VR = 28'sd104595;
  localparam logic signed [27:0] K_VG = 28'sd53281;
  localparam logic signed [27:0] K_UG = 28'sd25625;

  // planar chroma scale (x/256) and green mix (x/128)
  localparam logic signed [17:0] K_US = 18'sd475;
  localparam logic signed [17:0] K_VS = 18'sd403;
  localparam logic [13:0]        K_YG = 14'd51;
  localparam logic [13:0]        K_RG = 14'd38;
  localparam logic [13:0]        K_BG = 14'd13;

  function automatic logic [7:0] clip8(input logic signed [15:0] v);
    logic [7:0] res;
    if (v < 16'sd0) begin
      res = 8'd0;
    end else if (v > 16'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  function automatic logic [PIX_W-1:0] pack555(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
    return {r[7:3], g[7:3], b[7:3]};
  endfunction

endpackage

// ===== rtl/core/y2r_packed_pix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_packed_pix
// one pixel through the 16.16 studio-range matrix, clipped and packed
// ----------------------------------------------------------------------------
module y2r_packed_pix (
  input  logic [7:0]                 y,
  input  logic [7:0]                 u,
  input  logic [7:0]                 v,
  output logic [y2r_pkg::PIX_W-1:0]  pix
);
  import y2r_pkg::*;

  logic signed [9:0]  yd;
  logic signed [9:0]  du;
  logic signed [9:0]  dv;
  logic signed [27:0] c;
  logic signed [27:0] b_sum;
  logic signed [27:0] g_sum;
  logic signed [27:0] r_sum;
  logic [7:0]         r;
  logic [7:0]         g;
  logic [7:0]         b;

  always_comb begin
    yd    = $signed({2'b00, y}) - 10'sd16;
    du    = $signed({2'b00, u}) - 10'sd128;
    dv    = $signed({2'b00, v}) - 10'sd128;
    c     = yd * K_Y;
    b_sum = c + du * K_UB;
    g_sum = c - dv * K_VG - du * K_UG;
    r_sum = c + dv * K_VR;
    // floor shift by 16 is the upper slice
    b     = clip8(16'($signed(b_sum[27:16])));
    g     = clip8(16'($signed(g_sum[27:16])));
    r     = clip8(16'($signed(r_sum[27:16])));
    pix   = pack555(r, g, b);
  end

endmodule

// ===== rtl/core/y2r_planar_pix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_planar_pix
// one planar pixel from pre-scaled chroma, green derived from clipped r and b
// ----------------------------------------------------------------------------
module y2r_planar_pix (
  input  logic [7:0]                 y,
  input  logic signed [9:0]          us,
  input  logic signed [9:0]          vs,
  output logic [y2r_pkg::PIX_W-1:0]  pix
);
  import y2r_pkg::*;

  logic signed [10:0] r_sum;
  logic signed [10:0] b_sum;
  logic signed [10:0] g_sum;
  logic [13:0]        y_mix;
  logic [13:0]        rb_mix;
  logic [7:0]         r;
  logic [7:0]         g;
  logic [7:0]         b;

  always_comb begin
    r_sum  = 11'(vs) + $signed({3'b000, y});
    b_sum  = 11'(us) + $signed({3'b000, y});
    r      = clip8(16'(r_sum));
    b      = clip8(16'(b_sum));
    y_mix  = 14'(y) * K_YG;
    rb_mix = 14'(r) * K_RG + 14'(b) * K_BG;
    g_sum  = $signed({3'b000, y}) + $signed({4'b0000, y_mix[13:7]})
           - $signed({4'b0000, rb_mix[13:7]});
    g      = clip8(16'(g_sum));
    pix    = pack555(r, g, b);
  end

endmodule

// ===== rtl/core/yuv422_to_rgb555_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv422_to_rgb555_converter
// path: an accepted input beat passes the input register, then the result register, to out_
// throughput: one pixel pair per cycle while out_tready does not stall, set by the input register feeding a
//   single combinational pass into the result register
// reset: rst_n synchronous, active low; clears both valid flags and sets
//   source_format to yuy2
// ----------------------------------------------------------------------------
module yuv422_to_rgb555_converter (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write: source_format
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  // input beats
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // byte_0 [7:0], byte_1 [15:8], byte_2 [23:16], byte_3 [31:24]
  input  logic        in_tlast,   // frame_end_in
  // result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pixel_first [14:0], pixel_second [29:15], zero [31:30]
  output logic        out_tlast   // frame_end_out
);
  import y2r_pkg::*;

  // format register
  logic [FMT_W-1:0] fmt_r;

  // input register stage
  logic        s1_vld_r;
  logic        s1_vld_nxt;
  logic [31:0] s1_data_r;
  logic        s1_last_r;

  // result register stage
  logic             out_vld_r;
  logic             out_vld_nxt;
  logic [PIX_W-1:0] out_pix0_r;
  logic [PIX_W-1:0] out_pix1_r;
  logic             out_last_r;

  logic out_adv;
  logic in_acc;

  // byte routing
  logic [7:0] b0, b1, b2, b3;
  logic [7:0] pk_y0, pk_y1, pk_u, pk_v;

  // planar chroma scaling, shared by both pixels of the pair
  logic signed [9:0]  pl_du;
  logic signed [9:0]  pl_dv;
  logic signed [17:0] us_prod;
  logic signed [17:0] vs_prod;
  logic signed [9:0]  pl_us;
  logic signed [9:0]  pl_vs;

  logic [PIX_W-1:0] pk_pix0, pk_pix1;
  logic [PIX_W-1:0] pl_pix0, pl_pix1;
  logic [PIX_W-1:0] pix0_nxt, pix1_nxt;

  // handshake: the result register frees when empty or being taken
  assign cfg_ready = 1'b1;
  assign out_adv   = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || out_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (out_adv) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_adv ? s1_vld_r : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r     <= FMT_YUY2;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        fmt_r <= cfg_data;
      end
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (out_adv && s1_vld_r) begin
      out_pix0_r <= pix0_nxt;
      out_pix1_r <= pix1_nxt;
      out_last_r <= s1_last_r;
    end
  end

  assign b0 = s1_data_r[7:0];
  assign b1 = s1_data_r[15:8];
  assign b2 = s1_data_r[23:16];
  assign b3 = s1_data_r[31:24];

  // uyvy carries the byte pairs swapped; put them back in yuy2 order
  always_comb begin
    if (fmt_r == FMT_UYVY) begin
      pk_y0 = b1;
      pk_u  = b0;
      pk_y1 = b3;
      pk_v  = b2;
    end else begin
      pk_y0 = b0;
      pk_u  = b1;
      pk_y1 = b2;
      pk_v  = b3;
    end
  end

  // yv12 pair order is y0, y1, u, v; floor shift by 8 is the upper slice
  always_comb begin
    pl_du   = $signed({2'b00, b2}) - 10'sd128;
    pl_dv   = $signed({2'b00, b3}) - 10'sd128;
    us_prod = pl_du * K_US;
    vs_prod = pl_dv * K_VS;
    pl_us   = us_prod[17:8];
    pl_vs   = vs_prod[17:8];
  end

  y2r_packed_pix u_pk0 (.y(pk_y0), .u(pk_u), .v(pk_v), .pix(pk_pix0));
  y2r_packed_pix u_pk1 (.y(pk_y1), .u(pk_u), .v(pk_v), .pix(pk_pix1));
  y2r_planar_pix u_pl0 (.y(b0), .us(pl_us), .vs(pl_vs), .pix(pl_pix0));
  y2r_planar_pix u_pl1 (.y(b1), .us(pl_us), .vs(pl_vs), .pix(pl_pix1));

  // reserved format code gives black pixels, flag still passes
  always_comb begin
    unique case (fmt_r)
      FMT_YUY2, FMT_UYVY: begin
        pix0_nxt = pk_pix0;
        pix1_nxt = pk_pix1;
      end
      FMT_YV12: begin
        pix0_nxt = pl_pix0;
        pix1_nxt = pl_pix1;
      end
      default: begin
        pix0_nxt = '0;
        pix1_nxt = '0;
      end
    endcase
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_pix1_r, out_pix0_r};
  assign out_tlast  = out_last_r;

  // a waiting pair moves on whenever the result register can take it
  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && out_adv |=> out_vld_r)
    else $error("pair in input register not moved to result register");

  // frame flag follows its own pair
  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && out_adv |=> out_last_r == $past(s1_last_r))
    else $error("frame end flag out of step with its pair");

  // both stages empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_vld_r && !s1_vld_r)
    else $error("stage valid set after reset");

endmodule
